[rtl/core/environmental_sensor_compensation_macros.svh]
// Assertion macros shared by the environmental sensor compensation RTL.
`ifndef ENVIRONMENTAL_SENSOR_COMPENSATION_MACROS_SVH
`define ENVIRONMENTAL_SENSOR_COMPENSATION_MACROS_SVH
`ifndef SYNTH
`define ESC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("esc assertion failed");
`define ESC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("esc assertion failed");
`else
`define ESC_ASSERT_SAME(label, clk, rstn, ante, cons)
`define ESC_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/esc_pkg.sv]
// Types, constants and helper functions of the environmental sensor compensation.
`default_nettype none
package esc_pkg;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
        logic [15:0] raw_humidity;
    } esc_in_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_pa;
        logic               pressure_valid;
        logic [16:0]        humidity_q10;
    } esc_out_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [16:0]        humidity_q10;
        logic               pressure_valid;
        logic               quo_neg;
    } esc_side_t;

    localparam logic [2:0] RegTemp      = 3'd0;
    localparam logic [2:0] RegPressLow  = 3'd1;
    localparam logic [2:0] RegPressHigh = 3'd2;
    localparam logic [2:0] RegPressLast = 3'd3;
    localparam logic [2:0] RegHum       = 3'd4;

    localparam logic [32:0] PressTFineOffset = 33'd128000;
    localparam logic [63:0] PressBase        = 64'd1048576;
    localparam logic [11:0] PressScale       = 12'd3125;
    localparam logic [63:0] PressW1Bias      = 64'h0000_8000_0000_0000;
    localparam logic [31:0] HumTFineOffset   = 32'd76800;
    localparam logic [31:0] HumLimit         = 32'd419430400;
    localparam logic [16:0] HumMax           = 17'd102400;
    localparam logic [31:0] HumBias          = 32'd2097152;
    localparam logic [31:0] HumRoundA        = 32'd16384;
    localparam logic [31:0] HumLinear        = 32'd32768;
    localparam logic [31:0] HumRoundB        = 32'd8192;
    localparam logic [31:0] TempRound        = 32'd128;
    localparam logic [31:0] TempScale        = 32'd5;

    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
        return $signed(x) >>> s;
    endfunction

endpackage
`default_nettype wire

[rtl/core/esc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband fields.
`default_nettype none
module esc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_vld,
    input  logic [63:0]         in_num,
    input  logic [30:0]         in_den,
    input  esc_pkg::esc_side_t  in_side,
    output logic                out_vld,
    output logic [63:0]         out_quo,
    output esc_pkg::esc_side_t  out_side
);
    import esc_pkg::*;

    localparam int NumW = 64;
    localparam int DenW = 31;

    logic [NumW-1:0] num_w  [0:NumW];
    logic [DenW-1:0] rem_w  [0:NumW];
    logic [DenW-1:0] den_w  [0:NumW];
    esc_side_t       side_w [0:NumW];
    logic            vld_w  [0:NumW];

    assign num_w[0]  = in_num;
    assign rem_w[0]  = '0;
    assign den_w[0]  = in_den;
    assign side_w[0] = in_side;
    assign vld_w[0]  = in_vld;

    for (genvar k = 0; k < NumW; k++) begin : g_step
        logic [DenW:0]   trial;
        logic            fits;
        logic [NumW-1:0] num_next;
        logic [DenW-1:0] rem_next;
        logic [NumW-1:0] num_reg;
        logic [DenW-1:0] rem_reg;
        logic [DenW-1:0] den_reg;
        esc_side_t       side_reg;
        logic            vld_reg;

        always_comb begin
            trial    = {rem_w[k], num_w[k][NumW-1]};
            fits     = trial >= {1'b0, den_w[k]};
            num_next = {num_w[k][NumW-2:0], fits};
            rem_next = fits ? DenW'(trial - {1'b0, den_w[k]}) : trial[DenW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg <= 1'b0;
            end else if (en) begin
                vld_reg <= vld_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg  <= num_next;
                rem_reg  <= rem_next;
                den_reg  <= den_w[k];
                side_reg <= side_w[k];
            end
        end

        assign num_w[k+1]  = num_reg;
        assign rem_w[k+1]  = rem_reg;
        assign den_w[k+1]  = den_reg;
        assign side_w[k+1] = side_reg;
        assign vld_w[k+1]  = vld_reg;
    end

    assign out_vld  = vld_w[NumW];
    assign out_quo  = num_w[NumW];
    assign out_side = side_w[NumW];

endmodule
`default_nettype wire

[rtl/core/environmental_sensor_compensation.sv]
// Top level of the environmental sensor compensation pipeline.
//
// Usage: raw temperature, pressure and humidity readings enter as one item on the
// s_ channel (valid/ready) and the compensated frame leaves as one item on the m_
// channel. Calibration words are written through the APB-style port; the user must
// write them only while the block is idle, as the block does not enforce this.
// Register i lies at byte address 8*i, and pready is always high. Throughput is one
// item per clock while the skid register is empty. An item passes through ten
// stages of temperature, pressure and humidity arithmetic, sixty-four stages of the
// pressure divider (one quotient bit per stage), six stages of pressure refinement
// and the output register before its result appears on m_valid. A skid register
// behind the output register keeps s_ready high while the receiver stalls until a
// valid item fills it; then the whole pipeline holds, losing and repeating nothing.
// Reset clears every valid bit and the calibration registers, which return to zero.
`default_nettype none
`include "environmental_sensor_compensation_macros.svh"
module environmental_sensor_compensation (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  esc_pkg::esc_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output esc_pkg::esc_out_t  m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import esc_pkg::*;

    // Configuration registers
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_lo_reg;
    logic [63:0] press_hi_reg;
    logic [15:0] press_last_reg;
    logic [63:0] hum_coeffs_reg;
    logic        cfg_wr;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg <= '0;
            press_lo_reg    <= '0;
            press_hi_reg    <= '0;
            press_last_reg  <= '0;
            hum_coeffs_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                RegTemp:      temp_coeffs_reg <= pwdata[47:0];
                RegPressLow:  press_lo_reg    <= pwdata;
                RegPressHigh: press_hi_reg    <= pwdata;
                RegPressLast: press_last_reg  <= pwdata[15:0];
                RegHum:       hum_coeffs_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            RegTemp:      prdata = {16'b0, temp_coeffs_reg};
            RegPressLow:  prdata = press_lo_reg;
            RegPressHigh: prdata = press_hi_reg;
            RegPressLast: prdata = {48'b0, press_last_reg};
            RegHum:       prdata = hum_coeffs_reg;
            default:      prdata = '0;
        endcase
    end

    // Calibration fields
    logic [15:0]        t1;
    logic [31:0]        t2x, t3x;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
    logic [7:0]         h1, h3;
    logic [31:0]        h2x, h4x, h5x, h6x;
    logic [63:0]        p7_term;

    assign t1  = temp_coeffs_reg[15:0];
    assign t2x = {{16{temp_coeffs_reg[31]}}, temp_coeffs_reg[31:16]};
    assign t3x = {{16{temp_coeffs_reg[47]}}, temp_coeffs_reg[47:32]};
    assign p1  = press_lo_reg[15:0];
    assign p2  = press_lo_reg[31:16];
    assign p3  = press_lo_reg[47:32];
    assign p4  = press_lo_reg[63:48];
    assign p5  = press_hi_reg[15:0];
    assign p6  = press_hi_reg[31:16];
    assign p7  = press_hi_reg[47:32];
    assign p8  = press_hi_reg[63:48];
    assign p9  = press_last_reg;
    assign h1  = hum_coeffs_reg[7:0];
    assign h2x = {{16{hum_coeffs_reg[23]}}, hum_coeffs_reg[23:8]};
    assign h3  = hum_coeffs_reg[31:24];
    assign h4x = {{20{hum_coeffs_reg[43]}}, hum_coeffs_reg[43:32]};
    assign h5x = {{20{hum_coeffs_reg[55]}}, hum_coeffs_reg[55:44]};
    assign h6x = {{24{hum_coeffs_reg[63]}}, hum_coeffs_reg[63:56]};
    assign p7_term = {{48{p7[15]}}, p7} << 4;

    // Pipeline control
    logic        adv;
    logic [10:1] fvld_reg;
    logic [6:1]  pvld_reg;
    logic        div_vld;
    logic        out_valid_reg, skid_valid_reg;
    esc_out_t    out_reg, skid_reg;

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fvld_reg <= '0;
            pvld_reg <= '0;
        end else if (adv) begin
            fvld_reg <= {fvld_reg[9:1], s_valid};
            pvld_reg <= {pvld_reg[5:1], div_vld};
        end
    end

    // Stage 1
    logic [31:0] s1_a, s1_b;
    logic [31:0] s1_pa_next, s1_bb_next, s1_pa_reg, s1_bb_reg;
    logic [19:0] s1_adcp_reg;
    logic [15:0] s1_adch_reg;

    assign s1_a = {15'b0, s_data.raw_temperature[19:3]} - {15'b0, t1, 1'b0};
    assign s1_b = {16'b0, s_data.raw_temperature[19:4]} - {16'b0, t1};
    assign s1_pa_next = s1_a * t2x;
    assign s1_bb_next = s1_b * s1_b;

    // Stage 2
    logic [31:0] s2_v1_next, s2_m_next, s2_v1_reg, s2_m_reg;
    logic [19:0] s2_adcp_reg;
    logic [15:0] s2_adch_reg;

    assign s2_v1_next = asr32(s1_pa_reg, 11);
    assign s2_m_next  = asr32(s1_bb_reg, 12) * t3x;

    // Stage 3
    logic [31:0] s3_tfine_next, s3_tfine_reg;
    logic [19:0] s3_adcp_reg;
    logic [15:0] s3_adch_reg;

    assign s3_tfine_next = s2_v1_reg + asr32(s2_m_reg, 14);

    // Stage 4
    logic [31:0]        s4_temp_next, s4_temp_reg, s4_h_next, s4_h_reg;
    logic signed [32:0] s4_w1_next, s4_w1_reg;
    logic [19:0]        s4_adcp_reg;
    logic [15:0]        s4_adch_reg;

    assign s4_temp_next = asr32(s3_tfine_reg * TempScale + TempRound, 8);
    assign s4_w1_next   = {s3_tfine_reg[31], s3_tfine_reg} - PressTFineOffset;
    assign s4_h_next    = s3_tfine_reg - HumTFineOffset;

    // Stage 5
    logic signed [65:0] s5_sq_full;
    logic [63:0]        s5_sq_next;
    logic signed [63:0] s5_sq_reg;
    logic signed [48:0] s5_pw5_next, s5_pw2_next, s5_pw5_reg, s5_pw2_reg;
    logic [31:0]        s5_ta_next, s5_hm6_next, s5_hm3_next;
    logic [31:0]        s5_ta_reg, s5_hm6_reg, s5_hm3_reg, s5_temp_reg;
    logic [19:0]        s5_adcp_reg;

    assign s5_sq_full  = s4_w1_reg * s4_w1_reg;
    assign s5_sq_next  = s5_sq_full[63:0];
    assign s5_pw5_next = s4_w1_reg * p5;
    assign s5_pw2_next = s4_w1_reg * p2;
    assign s5_ta_next  = {2'b0, s4_adch_reg, 14'b0} - (h4x << 20) - h5x * s4_h_reg + HumRoundA;
    assign s5_hm6_next = s4_h_reg * h6x;
    assign s5_hm3_next = s4_h_reg * {24'b0, h3};

    // Stage 6
    logic signed [79:0] s6_a_full, s6_b_full;
    logic [63:0]        s6_a_reg, s6_b_reg;
    logic signed [48:0] s6_pw5_reg, s6_pw2_reg;
    logic [31:0]        s6_ha_next, s6_q1_next, s6_ha_reg, s6_q1_reg, s6_temp_reg;
    logic [19:0]        s6_adcp_reg;

    assign s6_a_full  = s5_sq_reg * p6;
    assign s6_b_full  = s5_sq_reg * p3;
    assign s6_ha_next = asr32(s5_ta_reg, 15);
    assign s6_q1_next = asr32(s5_hm6_reg, 10) * (asr32(s5_hm3_reg, 11) + HumLinear);

    // Stage 7
    logic [63:0] s7_w2_next, s7_w1b_next, s7_w2_reg, s7_w1b_reg;
    logic [31:0] s7_r_next, s7_r_reg, s7_ha_reg, s7_temp_reg;
    logic [19:0] s7_adcp_reg;

    assign s7_w2_next = s6_a_reg + ({{15{s6_pw5_reg[48]}}, s6_pw5_reg} << 17)
                        + ({{48{p4[15]}}, p4} << 35);
    assign s7_w1b_next = asr64(s6_b_reg, 8) + ({{15{s6_pw2_reg[48]}}, s6_pw2_reg} << 12);
    assign s7_r_next   = (asr32(s6_q1_reg, 10) + HumBias) * h2x + HumRoundB;

    // Stage 8
    logic [79:0] s8_x_full;
    logic [63:0] s8_x_reg, s8_npre_next, s8_npre_reg;
    logic [31:0] s8_hh_next, s8_hh_reg, s8_temp_reg;

    assign s8_x_full    = (PressW1Bias + s7_w1b_reg) * p1;
    assign s8_npre_next = ((PressBase - {44'b0, s7_adcp_reg}) << 31) - s7_w2_reg;
    assign s8_hh_next   = s7_ha_reg * asr32(s7_r_reg, 14);

    // Stage 9
    logic [75:0] s9_num_full;
    logic [63:0] s9_num_reg;
    logic [30:0] s9_den_reg;
    logic [31:0] s9_hs, s9_sqh_next, s9_sqh_reg, s9_hh_reg, s9_temp_reg;

    assign s9_num_full = s8_npre_reg * PressScale;
    assign s9_hs       = asr32(s8_hh_reg, 15);
    assign s9_sqh_next = s9_hs * s9_hs;

    // Stage 10
    logic [63:0] s10_an_next, s10_an_reg;
    logic [30:0] s10_ad_next, s10_ad_reg;
    logic        s10_nz_reg, s10_qneg_reg;
    logic [31:0] s10_th_next, s10_th_reg, s10_hh_reg, s10_temp_reg;

    assign s10_an_next = s9_num_reg[63] ? 64'd0 - s9_num_reg : s9_num_reg;
    assign s10_ad_next = s9_den_reg[30] ? 31'd0 - s9_den_reg : s9_den_reg;
    assign s10_th_next = asr32(s9_sqh_reg, 7) * {24'b0, h1};

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_pa_reg    <= s1_pa_next;
            s1_bb_reg    <= s1_bb_next;
            s1_adcp_reg  <= s_data.raw_pressure;
            s1_adch_reg  <= s_data.raw_humidity;
            s2_v1_reg    <= s2_v1_next;
            s2_m_reg     <= s2_m_next;
            s2_adcp_reg  <= s1_adcp_reg;
            s2_adch_reg  <= s1_adch_reg;
            s3_tfine_reg <= s3_tfine_next;
            s3_adcp_reg  <= s2_adcp_reg;
            s3_adch_reg  <= s2_adch_reg;
            s4_temp_reg  <= s4_temp_next;
            s4_w1_reg    <= s4_w1_next;
            s4_h_reg     <= s4_h_next;
            s4_adcp_reg  <= s3_adcp_reg;
            s4_adch_reg  <= s3_adch_reg;
            s5_sq_reg    <= s5_sq_next;
            s5_pw5_reg   <= s5_pw5_next;
            s5_pw2_reg   <= s5_pw2_next;
            s5_ta_reg    <= s5_ta_next;
            s5_hm6_reg   <= s5_hm6_next;
            s5_hm3_reg   <= s5_hm3_next;
            s5_temp_reg  <= s4_temp_reg;
            s5_adcp_reg  <= s4_adcp_reg;
            s6_a_reg     <= s6_a_full[63:0];
            s6_b_reg     <= s6_b_full[63:0];
            s6_pw5_reg   <= s5_pw5_reg;
            s6_pw2_reg   <= s5_pw2_reg;
            s6_ha_reg    <= s6_ha_next;
            s6_q1_reg    <= s6_q1_next;
            s6_temp_reg  <= s5_temp_reg;
            s6_adcp_reg  <= s5_adcp_reg;
            s7_w2_reg    <= s7_w2_next;
            s7_w1b_reg   <= s7_w1b_next;
            s7_r_reg     <= s7_r_next;
            s7_ha_reg    <= s6_ha_reg;
            s7_temp_reg  <= s6_temp_reg;
            s7_adcp_reg  <= s6_adcp_reg;
            s8_x_reg     <= s8_x_full[63:0];
            s8_npre_reg  <= s8_npre_next;
            s8_hh_reg    <= s8_hh_next;
            s8_temp_reg  <= s7_temp_reg;
            s9_num_reg   <= s9_num_full[63:0];
            s9_den_reg   <= s8_x_reg[63:33];
            s9_sqh_reg   <= s9_sqh_next;
            s9_hh_reg    <= s8_hh_reg;
            s9_temp_reg  <= s8_temp_reg;
            s10_an_reg   <= s10_an_next;
            s10_ad_reg   <= s10_ad_next;
            s10_nz_reg   <= |s9_den_reg;
            s10_qneg_reg <= s9_num_reg[63] ^ s9_den_reg[30];
            s10_th_reg   <= s10_th_next;
            s10_hh_reg   <= s9_hh_reg;
            s10_temp_reg <= s9_temp_reg;
        end
    end

    // Humidity clamp, registered by the first divider stage
    logic [31:0] hum_raw;
    logic [16:0] hum_q10;
    esc_side_t   div_in_side, div_side;
    logic [63:0] div_quo;

    assign hum_raw = s10_hh_reg - asr32(s10_th_reg, 4);

    always_comb begin
        if (hum_raw[31]) begin
            hum_q10 = '0;
        end else if (hum_raw > HumLimit) begin
            hum_q10 = HumMax;
        end else begin
            hum_q10 = hum_raw[28:12];
        end
    end

    assign div_in_side.temperature_centi = s10_temp_reg;
    assign div_in_side.humidity_q10      = hum_q10;
    assign div_in_side.pressure_valid    = s10_nz_reg;
    assign div_in_side.quo_neg           = s10_qneg_reg;

    esc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (fvld_reg[10]),
        .in_num   (s10_an_reg),
        .in_den   (s10_ad_reg),
        .in_side  (div_in_side),
        .out_vld  (div_vld),
        .out_quo  (div_quo),
        .out_side (div_side)
    );

    // Pressure refinement after the division
    logic signed [63:0] d1_p_next, d1_p_reg;
    logic [63:0]        d2_ps;
    logic [63:0]        d2_lo_next, d2_lo_reg;
    logic [31:0]        d2_cr_next, d2_cr_reg;
    logic signed [79:0] d2_x2_full;
    logic [63:0]        d2_x2_reg, d3_x2_reg, d4_x2_reg;
    logic signed [63:0] d2_p_reg, d3_p_reg, d4_p_reg;
    logic signed [63:0] d3_pp_next, d3_pp_reg;
    logic signed [79:0] d4_y_full;
    logic [63:0]        d4_y_reg;
    logic [63:0]        d5_s_next, d5_s_reg;
    logic [63:0]        d6_adj;
    esc_side_t          d1_side_reg, d2_side_reg, d3_side_reg, d4_side_reg, d5_side_reg;
    esc_out_t           d6_out_next, d6_out_reg;

    assign d1_p_next  = div_side.quo_neg ? 64'd0 - div_quo : div_quo;
    assign d2_ps      = asr64(d1_p_reg, 13);
    assign d2_lo_next = d2_ps[31:0] * d2_ps[31:0];
    assign d2_cr_next = d2_ps[31:0] * d2_ps[63:32];
    assign d2_x2_full = d1_p_reg * p8;
    assign d3_pp_next = d2_lo_reg + {d2_cr_reg[30:0], 1'b0, 32'b0};
    assign d4_y_full  = d3_pp_reg * p9;
    assign d5_s_next  = asr64(d4_p_reg + asr64(d4_y_reg, 25) + asr64(d4_x2_reg, 19), 8)
                        + p7_term;
    assign d6_adj     = d5_s_reg + (d5_s_reg[63] ? 64'd255 : 64'd0);

    assign d6_out_next.temperature_centi = d5_side_reg.temperature_centi;
    assign d6_out_next.pressure_pa       = d5_side_reg.pressure_valid ? d6_adj[39:8] : '0;
    assign d6_out_next.pressure_valid    = d5_side_reg.pressure_valid;
    assign d6_out_next.humidity_q10      = d5_side_reg.humidity_q10;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_p_reg    <= d1_p_next;
            d1_side_reg <= div_side;
            d2_lo_reg   <= d2_lo_next;
            d2_cr_reg   <= d2_cr_next;
            d2_x2_reg   <= d2_x2_full[63:0];
            d2_p_reg    <= d1_p_reg;
            d2_side_reg <= d1_side_reg;
            d3_pp_reg   <= d3_pp_next;
            d3_x2_reg   <= d2_x2_reg;
            d3_p_reg    <= d2_p_reg;
            d3_side_reg <= d2_side_reg;
            d4_y_reg    <= d4_y_full[63:0];
            d4_x2_reg   <= d3_x2_reg;
            d4_p_reg    <= d3_p_reg;
            d4_side_reg <= d3_side_reg;
            d5_s_reg    <= d5_s_next;
            d5_side_reg <= d4_side_reg;
            d6_out_reg  <= d6_out_next;
        end
    end

    // Output register and skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= pvld_reg[6];
            end
        end else if (pvld_reg[6] && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : d6_out_reg;
        end else if (!skid_valid_reg) begin
            skid_reg <= d6_out_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `ESC_ASSERT_SAME(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `ESC_ASSERT_NEXT(a_stall_fills_skid, aclk, aresetn, out_valid_reg && !m_ready && pvld_reg[6] && !skid_valid_reg, skid_valid_reg)
    `ESC_ASSERT_SAME(a_invalid_press_zero, aclk, aresetn, m_valid && !m_data.pressure_valid, m_data.pressure_pa == 32'd0)
    `ESC_ASSERT_SAME(a_hum_in_range, aclk, aresetn, m_valid, m_data.humidity_q10 <= HumMax)
    `ESC_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, fvld_reg[1])

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench of the environmental sensor compensation block.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import esc_pkg::*;

    localparam int unsigned LATENCY = 80;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    esc_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    esc_out_t    m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    environmental_sensor_compensation dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    class frame_scoreboard;
        logic [47:0] temp_cal;
        logic [63:0] press_cal_lo;
        logic [63:0] press_cal_hi;
        logic [15:0] press_cal_p9;
        logic [63:0] hum_cal;
        esc_out_t    pending[$];
        int          errors;
        int          checked;

        function void clear_cal();
            temp_cal = '0;
            press_cal_lo = '0;
            press_cal_hi = '0;
            press_cal_p9 = '0;
            hum_cal = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_cal(logic [2:0] idx, logic [63:0] v);
            case (idx)
                RegTemp: temp_cal = v[47:0];
                RegPressLow: press_cal_lo = v;
                RegPressHigh: press_cal_hi = v;
                RegPressLast: press_cal_p9 = v[15:0];
                RegHum: hum_cal = v;
                default: ;
            endcase
        endfunction

        function esc_out_t compensate(esc_in_t f);
            esc_out_t r;
            logic signed [31:0] t1, t2, t3, a, b, v1, v2, tfine;
            logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic signed [63:0] w1, w2, p, ps, x1, x2, num;
            logic signed [31:0] h1, h2, h3, h4, h5, h6, h, ha, hb, hs;
            t1 = {16'd0, temp_cal[15:0]};
            t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
            t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
            a = {15'd0, f.raw_temperature[19:3]} - (t1 <<< 1);
            v1 = (a * t2) >>> 11;
            b = {16'd0, f.raw_temperature[19:4]} - t1;
            v2 = (((b * b) >>> 12) * t3) >>> 14;
            tfine = v1 + v2;
            r.temperature_centi = (tfine * 32'sd5 + 32'sd128) >>> 8;

            p1 = {48'd0, press_cal_lo[15:0]};
            p2 = {{48{press_cal_lo[31]}}, press_cal_lo[31:16]};
            p3 = {{48{press_cal_lo[47]}}, press_cal_lo[47:32]};
            p4 = {{48{press_cal_lo[63]}}, press_cal_lo[63:48]};
            p5 = {{48{press_cal_hi[15]}}, press_cal_hi[15:0]};
            p6 = {{48{press_cal_hi[31]}}, press_cal_hi[31:16]};
            p7 = {{48{press_cal_hi[47]}}, press_cal_hi[47:32]};
            p8 = {{48{press_cal_hi[63]}}, press_cal_hi[63:48]};
            p9 = {{48{press_cal_p9[15]}}, press_cal_p9};
            w1 = {{32{tfine[31]}}, tfine} - 64'sd128000;
            w2 = w1 * w1 * p6;
            w2 = w2 + ((w1 * p5) <<< 17);
            w2 = w2 + (p4 <<< 35);
            w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) <<< 12);
            w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;
            r.pressure_pa = '0;
            r.pressure_valid = 1'b0;
            if (w1 != 0) begin
                p = 64'sd1048576 - {44'd0, f.raw_pressure};
                num = ((p <<< 31) - w2) * 64'sd3125;
                // The most negative numerator over minus one wraps onto itself.
                if (w1 == -64'sd1) p = -num;
                else p = num / w1;
                ps = p >>> 13;
                x1 = (p9 * ps * ps) >>> 25;
                x2 = (p8 * p) >>> 19;
                p = ((p + x1 + x2) >>> 8) + (p7 <<< 4);
                p = p / 64'sd256;
                r.pressure_pa = p[31:0];
                r.pressure_valid = 1'b1;
            end

            h1 = {24'd0, hum_cal[7:0]};
            h2 = {{16{hum_cal[23]}}, hum_cal[23:8]};
            h3 = {24'd0, hum_cal[31:24]};
            h4 = {{20{hum_cal[43]}}, hum_cal[43:32]};
            h5 = {{20{hum_cal[55]}}, hum_cal[55:44]};
            h6 = {{24{hum_cal[63]}}, hum_cal[63:56]};
            h = tfine - 32'sd76800;
            ha = (($signed({16'd0, f.raw_humidity}) <<< 14) - (h4 <<< 20) - h5 * h
                  + 32'sd16384) >>> 15;
            hb = (((h * h6) >>> 10) * (((h * h3) >>> 11) + 32'sd32768)) >>> 10;
            hb = ((hb + 32'sd2097152) * h2 + 32'sd8192) >>> 14;
            h = ha * hb;
            hs = h >>> 15;
            h = h - ((((hs * hs) >>> 7) * h1) >>> 4);
            if (h < 0) r.humidity_q10 = '0;
            else if (h > 32'sd419430400) r.humidity_q10 = HumMax;
            else r.humidity_q10 = h[28:12];
            return r;
        endfunction

        function void note_frame(esc_in_t f);
            pending.push_back(compensate(f));
        endfunction

        function void check_result(esc_out_t got);
            esc_out_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.temperature_centi !== want.temperature_centi) begin
                $display("%0t: temperature expected %0d got %0d", $time,
                         want.temperature_centi, got.temperature_centi);
                errors++;
            end
            if (got.pressure_pa !== want.pressure_pa) begin
                $display("%0t: pressure expected %0d got %0d", $time,
                         want.pressure_pa, got.pressure_pa);
                errors++;
            end
            if (got.pressure_valid !== want.pressure_valid) begin
                $display("%0t: pressure flag expected %0b got %0b", $time,
                         want.pressure_valid, got.pressure_valid);
                errors++;
            end
            if (got.humidity_q10 !== want.humidity_q10) begin
                $display("%0t: humidity expected %0d got %0d", $time,
                         want.humidity_q10, got.humidity_q10);
                errors++;
            end
        endfunction
    endclass

    frame_scoreboard board = new();
    int sent;
    int rx_wait = 0;

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) board.note_frame(s_data);
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
    end

    always @(posedge aclk) begin
        int w;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                w = $urandom_range(0, 4);
                m_ready <= (w == 0);
                rx_wait <= (w == 0) ? 0 : w - 1;
            end else if (!m_ready) begin
                if (rx_wait == 0) m_ready <= 1'b1;
                else rx_wait <= rx_wait - 1;
            end
        end
    end

    task automatic write_cal(logic [2:0] idx, logic [63:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_cal(idx, v);
    endtask

    task automatic send_frame(esc_in_t f, bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= f;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic esc_in_t rand_frame();
        esc_in_t f;
        f.raw_temperature = $urandom_range(0, 3) == 0 ? 20'($urandom) :
                            20'($urandom_range(400000, 600000));
        f.raw_pressure = $urandom_range(0, 3) == 0 ? 20'($urandom) :
                         20'($urandom_range(250000, 450000));
        f.raw_humidity = 16'($urandom);
        if ($urandom_range(0, 19) == 0) f.raw_pressure = '1;
        if ($urandom_range(0, 19) == 0) f.raw_temperature = '0;
        return f;
    endfunction

    task automatic typical_cal();
        write_cal(RegTemp, {16'sd50, 16'sd26435, 16'd27504});
        write_cal(RegPressLow, {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477});
        write_cal(RegPressHigh, {-16'sd19000, 16'sd15500, -16'sd7, 16'sd140});
        write_cal(RegPressLast, 64'(16'sd6000));
        write_cal(RegHum, {8'd30, 12'd0, 12'd322, 8'd0, 16'sd360, 8'd75});
    endtask

    task automatic random_cal();
        write_cal(RegTemp, {$urandom, $urandom});
        write_cal(RegPressLow, {$urandom, $urandom});
        write_cal(RegPressHigh, {$urandom, $urandom});
        write_cal(RegPressLast, {$urandom, $urandom});
        write_cal(RegHum, {$urandom, $urandom});
    endtask

    task automatic random_phase(int n, bit idle);
        for (int i = 0; i < n; i++) send_frame(rand_frame(), idle && $urandom_range(0, 1));
        drain();
    endtask

    initial begin
        esc_in_t f;
        board.clear_cal();
        sent = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero calibration leaves the pressure divisor at zero.
        send_frame('0, 1'b0);
        send_frame('1, 1'b0);
        drain();

        typical_cal();
        f = '0;
        send_frame(f, 1'b0);
        f = '1;
        send_frame(f, 1'b0);
        f = '{20'd519888, 20'd415148, 16'd0};
        send_frame(f, 1'b1);
        f = '{20'd519888, 20'd415148, 16'hFFFF};
        send_frame(f, 1'b1);
        f = '{20'hFFFFF, 20'd0, 16'd30000};
        send_frame(f, 1'b0);
        f = '{20'd0, 20'hFFFFF, 16'd30000};
        send_frame(f, 1'b0);
        f = '{20'h80000, 20'h80000, 16'h8000};
        send_frame(f, 1'b1);
        drain();

        // Extreme calibration words.
        write_cal(RegTemp, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(RegPressLow, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(RegPressHigh, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(RegPressLast, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(RegHum, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame('0, 1'b0);
        send_frame('1, 1'b0);
        send_frame(rand_frame(), 1'b0);
        drain();
        write_cal(RegTemp, 64'h0000_8000_8000_0000);
        write_cal(RegPressLow, 64'h8000_8000_8000_FFFF);
        write_cal(RegPressHigh, 64'h8000_8000_8000_8000);
        write_cal(RegPressLast, 64'h0000_0000_0000_8000);
        write_cal(RegHum, 64'h8080_0800_FF80_00FF);
        send_frame('0, 1'b0);
        send_frame('1, 1'b0);
        send_frame(rand_frame(), 1'b0);
        drain();

        typical_cal();
        random_phase(700, 1'b1);
        random_cal();
        random_phase(150, 1'b1);
        random_cal();
        random_phase(150, 1'b0);
        typical_cal();
        random_phase(530, 1'b1);

        $display("Sent %0d frames over several calibration sets; %0d results checked.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[environmental_sensor_compensation.f]
+incdir+rtl/core
rtl/core/esc_pkg.sv
rtl/core/esc_div.sv
rtl/core/environmental_sensor_compensation.sv
bench/tb_top.sv
